### rtl/rcsb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the frame-to-packet packer.
package rcsb_pkg;

	// Input frame geometry
	localparam int FRAME_LENGTH    = 18;
	localparam int ACTIVE_CHANNELS = 6;
	localparam int NBYTES          = 2 * ACTIVE_CHANNELS;
	localparam int POS_W           = $clog2(FRAME_LENGTH);
	localparam int BIDX_W          = $clog2(NBYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);
	localparam logic [POS_W-1:0] DATA_POS = POS_W'(2);

	localparam logic [7:0] HDR0 = 8'h55;
	localparam logic [7:0] HDR1 = 8'hFC;

	// Output packet geometry
	localparam int NCHAN      = 8;
	localparam int CH_BITS    = 11;
	localparam int CIDX_W     = $clog2(NCHAN);
	localparam int PACK_BITS  = NCHAN * CH_BITS;
	localparam int PACK_BYTES = PACK_BITS / 8;
	localparam int OUT_LEN    = 18;
	localparam int OCNT_W     = $clog2(OUT_LEN);
	localparam logic [OCNT_W-1:0] OUT_LAST = OCNT_W'(OUT_LEN - 1);
	localparam logic [OCNT_W-1:0] TAG_POS  = OCNT_W'(13);
	localparam logic [CIDX_W-1:0] CH_LAST  = CIDX_W'(NCHAN - 1);
	localparam logic [CIDX_W-1:0] FS_CHANNEL = CIDX_W'(2);

	// Channel conversion
	localparam logic [15:0] CH_LO      = 16'd1155;
	localparam logic [15:0] CH_HI      = 16'd1929;
	localparam logic [15:0] CH_NEUTRAL = 16'd1543;
	localparam logic [CH_BITS-1:0] SB_LO = CH_BITS'(173);
	localparam int D_W = 10;
	// (d * 1638) / 774 == (d * 91) / 43, done as d * ceil(91 * 2^22 / 43) >> 22;
	// exact for d up to 774 since the rounding error stays below 1/43.
	localparam int MUL_W       = 24;
	localparam int SCALE_SHIFT = 22;
	localparam logic [MUL_W-1:0] SCALE_MUL = MUL_W'(8876318);
	localparam int PROD_W = D_W + MUL_W;

	typedef struct packed {
		logic [ACTIVE_CHANNELS-1:0][15:0] words;
		logic                             failsafe;
	} job_t;

	// True when channel c carries data from the frame
	function automatic logic chan_present(input logic [CIDX_W-1:0] c);
		return (int'(c) < ACTIVE_CHANNELS) && (3 + 2 * int'(c) < FRAME_LENGTH);
	endfunction

	// Fixed bytes after the packed channel data
	function automatic logic [7:0] pkt_tail(input logic [OCNT_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			TAG_POS:                b = 8'h48;
			TAG_POS + OCNT_W'(1):   b = 8'h45;
			TAG_POS + OCNT_W'(2):   b = 8'h4C;
			TAG_POS + OCNT_W'(3):   b = 8'h4F;
			default:                b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### rtl/rcsb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and packet bytes.
interface rcsb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcsb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

### rtl/rcsb_front.sv
`timescale 1ns / 1ps
// Header search and channel byte capture; pushes one job per complete frame.
module rcsb_front
	import rcsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        failsafe,
	rcsb_in_if.sink     rx,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	logic [POS_W-1:0]            pos_q;
	logic [NBYTES-1:0][7:0]      chan_q;
	logic [NBYTES-1:0][7:0]      chan_nxt;
	logic [POS_W-1:0]            off;
	logic [BIDX_W-1:0]           widx;
	logic                        wr;
	logic                        take;
	logic                        at_last;

	assign at_last  = (pos_q == LAST_POS);
	assign rx.ready = job_ready || !at_last;
	assign take     = rx.valid && rx.ready;
	assign off      = pos_q - DATA_POS;
	assign widx     = off[BIDX_W-1:0];
	assign wr       = (pos_q >= DATA_POS) && (int'(off) < NBYTES);

	always_comb begin
		for (int i = 0; i < NBYTES; i++) begin
			chan_nxt[i] = (wr && int'(widx) == i) ? rx.rx_byte : chan_q[i];
		end
		for (int c = 0; c < ACTIVE_CHANNELS; c++) begin
			job.words[c] = {chan_nxt[2*c], chan_nxt[2*c+1]};
		end
		job.failsafe = failsafe;
	end

	assign job_valid = take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (pos_q == '0 && rx.rx_byte != HDR0) begin
				pos_q <= '0;
			end else if (pos_q == POS_W'(1) && rx.rx_byte != HDR1) begin
				pos_q <= '0;
			end else if (at_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr) begin
			chan_q[widx] <= rx.rx_byte;
		end
	end

endmodule

### rtl/rcsb_fifo.sv
`timescale 1ns / 1ps
// Two-entry job queue between front and back.
module rcsb_fifo
	import rcsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_job    = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

endmodule

### rtl/rcsb_back.sv
`timescale 1ns / 1ps
// Channel scaling (one channel per cycle), bit packing and packet byte output.
module rcsb_back
	import rcsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	rcsb_out_if.source  tx
);

	// Scaler
	logic                             sc_busy_q;
	logic                             issuing_q;
	logic [CIDX_W-1:0]                cnt_q;
	logic                             fs_q;
	logic [ACTIVE_CHANNELS-1:0][15:0] ch_sh_q;
	logic                             valid_s1;
	logic [CIDX_W-1:0]                idx_s1;
	logic [PROD_W-1:0]                prod_s1;
	logic [PACK_BITS-1:0]             pack_q;
	logic                             pk_full_q;

	logic [15:0]        v_raw;
	logic [15:0]        v_cl;
	logic [D_W-1:0]     d;
	logic [CH_BITS-1:0] sc;
	logic               load_job;

	// Emitter
	logic                 em_busy_q;
	logic [PACK_BITS-1:0] em_sh_q;
	logic [OCNT_W-1:0]    ocnt_q;
	logic                 tx_take;
	logic                 em_free;
	logic                 em_load;

	assign job_ready = !sc_busy_q && !pk_full_q;
	assign load_job  = job_valid && job_ready;

	always_comb begin
		if (fs_q) begin
			v_raw = (cnt_q == FS_CHANNEL) ? CH_LO : CH_NEUTRAL;
		end else if (chan_present(cnt_q)) begin
			v_raw = ch_sh_q[0];
		end else begin
			v_raw = CH_NEUTRAL;
		end
		if (v_raw > CH_HI) begin
			v_cl = CH_HI;
		end else if (v_raw < CH_LO) begin
			v_cl = CH_LO;
		end else begin
			v_cl = v_raw;
		end
		d  = D_W'(v_cl - CH_LO);
		sc = prod_s1[SCALE_SHIFT +: CH_BITS] + SB_LO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_busy_q <= 1'b0;
			issuing_q <= 1'b0;
			cnt_q     <= '0;
			valid_s1  <= 1'b0;
			pk_full_q <= 1'b0;
		end else begin
			if (load_job) begin
				sc_busy_q <= 1'b1;
				issuing_q <= 1'b1;
				cnt_q     <= '0;
			end else if (issuing_q) begin
				cnt_q <= cnt_q + CIDX_W'(1);
				if (cnt_q == CH_LAST) issuing_q <= 1'b0;
			end
			valid_s1 <= issuing_q;
			if (valid_s1 && idx_s1 == CH_LAST) begin
				sc_busy_q <= 1'b0;
				pk_full_q <= 1'b1;
			end else if (em_load) begin
				pk_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			ch_sh_q <= job.words;
			fs_q    <= job.failsafe;
		end else if (issuing_q) begin
			ch_sh_q <= ch_sh_q >> 16;
		end
		if (issuing_q) begin
			idx_s1  <= cnt_q;
			prod_s1 <= PROD_W'(d) * PROD_W'(SCALE_MUL);
		end
		// shift in from the top: channel 0 ends up in the low bits
		if (valid_s1) begin
			pack_q <= {sc, pack_q[PACK_BITS-1:CH_BITS]};
		end
	end

	// Emitter: one packet byte per cycle while tx.ready is high
	assign tx_take      = tx.valid && tx.ready;
	assign em_free      = !em_busy_q || (tx_take && ocnt_q == OUT_LAST);
	assign em_load      = pk_full_q && em_free;
	assign tx.valid     = em_busy_q;
	assign tx.last_byte = (ocnt_q == OUT_LAST);
	assign tx.out_byte  = (int'(ocnt_q) < PACK_BYTES) ? em_sh_q[7:0] : pkt_tail(ocnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_busy_q <= 1'b0;
			ocnt_q    <= '0;
		end else if (em_load) begin
			em_busy_q <= 1'b1;
			ocnt_q    <= '0;
		end else if (tx_take) begin
			if (ocnt_q == OUT_LAST) begin
				em_busy_q <= 1'b0;
			end else begin
				ocnt_q <= ocnt_q + OCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (em_load) begin
			em_sh_q <= pack_q;
		end else if (tx_take) begin
			em_sh_q <= em_sh_q >> 8;
		end
	end

endmodule

### rtl/rc_frame_to_sbus_packer.sv
`timescale 1ns / 1ps
// Top level: frame search, job queue and packet builder for 18-byte channel packets.
// Throughput: one byte per cycle in and out while neither side stalls; a packet is 18 bytes (byte emitter).
// Path: from the last byte of a frame to the first packet byte a job passes through the queue,
//   the channel scaler (one channel at a time, with one multiplier stage) and the emitter load.
// Reset: arst_n clears frame position, queue, scaler and emitter state and failsafe_mode.
//   Stored channel bytes are not cleared and no clearing pass runs.
module rc_frame_to_sbus_packer
	import rcsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rcsb_in_if.sink     rx,
	rcsb_out_if.source  tx,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	// failsafe_mode: swap all channels for fixed safe positions
	logic failsafe_q;

	// front -> queue
	logic fr_valid;
	logic fr_ready;
	job_t fr_job;

	// queue -> back
	logic bk_valid;
	logic bk_ready;
	job_t bk_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failsafe_q <= 1'b0;
		end else if (cfg_wr_en) begin
			failsafe_q <= cfg_wr_data;
		end
	end

	// Front: hunt for the 0x55 0xFC header, capture channel bytes, push a job at frame end.
	// Only the final frame byte can stall, and only when the queue is full.
	rcsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.failsafe  (failsafe_q),
		.rx        (rx),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	// Queue: hold up to two complete frames so front and back stall independently.
	rcsb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_job   (fr_job),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_job    (bk_job)
	);

	// Back: scale eight channels into a packed 88-bit word, then stream 18 bytes.
	// Scaling of the next frame overlaps output of the current packet.
	rcsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.tx        (tx)
	);

endmodule
